@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int CELL_W = CHAR_W + ATTR_W;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] NULL_CHAR    = 8'h00;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_SET   = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // One screen cell: attribute in the high byte, character in the low byte.
  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

endpackage

@@ rtl/tcw_screen_ram.sv @@
// Screen cell memory: one write port and one registered read port.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  cell_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output cell_t         rdata_o
);

  cell_t mem [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/text_console_writer_core.sv @@
// Text console writer: a screen of character cells with a cursor, kept in one memory.
// A put, a set cursor and a null put pass through EXEC; a read adds RDWAIT; a newline
// steps through NL and FIN; a clear sweeps FILL then FIN; a scroll sweeps SCROLL first.
// The input is taken only in the idle state, so a new item waits until the last one has
// given its result; every sweep of the screen stalls the input.
// After reset a clearing pass blanks every cell of the screen before any item is taken.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: mode[1:0], char_code[9:2], position[20:10], zero fill.
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: cursor_cell[10:0], cell_char[18:11], cell_attr[26:19],
  // scrolled[27], zero fill.
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int CW    = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CMPW  = (CW > POS_W) ? CW : POS_W;

  localparam logic [CW-1:0]   CELLS_C    = CW'(CELLS);
  localparam logic [CW-1:0]   LAST_C     = CW'(CELLS - 1);
  localparam logic [CW-1:0]   COLS_C     = CW'(COLUMNS);
  localparam logic [CW-1:0]   LAST_ROW_C = CW'(CELLS - COLUMNS);
  localparam logic [CMPW-1:0] CELLS_X    = CMPW'(CELLS);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SCROLL,
    S_NL,
    S_RDWAIT,
    S_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cur_q, cur_d;
  logic [CW-1:0]      k_q, k_d;
  logic [CW-1:0]      nb_q, nb_d;
  logic               pend_q, pend_d;
  logic               pend_copy_q, pend_copy_d;
  logic [AW-1:0]      pend_addr_q, pend_addr_d;
  logic               scr_q, scr_d;
  mode_e              mode_q, mode_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [ATTR_W-1:0]  attr_q, attr_d;
  logic               ov_q, ov_d;
  logic [POS_W-1:0]   o_cur_q, o_cur_d;
  logic [CHAR_W-1:0]  o_char_q, o_char_d;
  logic [ATTR_W-1:0]  o_attr_q, o_attr_d;
  logic               o_scr_q, o_scr_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  tcw_screen_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0000, o_scr_q, o_attr_q, o_char_q, o_cur_q};

  always_comb begin
    logic              out_free;
    logic              fin;
    logic [CW-1:0]     fin_cur;
    logic [CHAR_W-1:0] fin_char;
    logic [ATTR_W-1:0] fin_attr;
    logic              copy;
    cell_t             blank;

    state_d     = state_q;
    cur_d       = cur_q;
    k_d         = k_q;
    nb_d        = nb_q;
    pend_d      = pend_q;
    pend_copy_d = pend_copy_q;
    pend_addr_d = pend_addr_q;
    scr_d       = scr_q;
    mode_d      = mode_q;
    char_d      = char_q;
    pos_d       = pos_q;
    attr_d      = attr_q;
    ov_d        = ov_q;
    o_cur_d     = o_cur_q;
    o_char_d    = o_char_q;
    o_attr_d    = o_attr_q;
    o_scr_d     = o_scr_q;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    out_free = !ov_q || m_axis_tready;
    fin      = 1'b0;
    fin_cur  = cur_q;
    fin_char = '0;
    fin_attr = '0;
    copy     = 1'b0;
    blank    = '{attr: attr_q, ch: BLANK_CHAR};

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (cfg_valid_i) begin
      attr_d = cfg_data_i;
    end

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[AW-1:0];
        mem_wdata = '{attr: RESET_ATTR, ch: BLANK_CHAR};
        if (k_q == LAST_C) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = mode_e'(s_axis_tdata[1:0]);
          char_d  = s_axis_tdata[9:2];
          pos_d   = s_axis_tdata[20:10];
          scr_d   = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_q)
          MODE_PUT: begin
            if (char_q == NULL_CHAR) begin
              fin = out_free;
            end else if (cur_q >= CELLS_C) begin
              // Scroll first; the put is decoded again once the screen has moved.
              k_d     = '0;
              pend_d  = 1'b0;
              scr_d   = 1'b1;
              state_d = S_SCROLL;
            end else if (char_q == NEWLINE_CHAR) begin
              nb_d    = COLS_C;
              state_d = S_NL;
            end else if (out_free) begin
              mem_we    = 1'b1;
              mem_waddr = cur_q[AW-1:0];
              mem_wdata = '{attr: attr_q, ch: char_q};
              cur_d     = cur_q + 1'b1;
              fin       = 1'b1;
              fin_cur   = cur_q + 1'b1;
            end
          end
          MODE_CLEAR: begin
            k_d     = '0;
            state_d = S_FILL;
          end
          MODE_SET: begin
            if (out_free) begin
              if (CMPW'(pos_q) > CELLS_X) begin
                fin_cur = CELLS_C;
              end else begin
                fin_cur = CW'(pos_q);
              end
              cur_d = fin_cur;
              fin   = 1'b1;
            end
          end
          MODE_READ: begin
            if (CMPW'(pos_q) < CELLS_X) begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_q);
              state_d   = S_RDWAIT;
            end else begin
              fin = out_free;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[AW-1:0];
        mem_wdata = blank;
        if (k_q == LAST_C) begin
          k_d     = '0;
          cur_d   = '0;
          state_d = S_FIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      S_SCROLL: begin
        // Reads run COLUMNS cells ahead of the writes, so the two never meet.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_q;
          mem_wdata = pend_copy_q ? mem_rdata : blank;
        end
        if (k_q != CELLS_C) begin
          copy        = (k_q < LAST_ROW_C);
          mem_re      = copy;
          mem_raddr   = AW'(k_q + COLS_C);
          pend_d      = 1'b1;
          pend_copy_d = copy;
          pend_addr_d = k_q[AW-1:0];
          k_d         = k_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            k_d     = '0;
            cur_d   = LAST_ROW_C;
            state_d = S_EXEC;
          end
        end
      end

      S_NL: begin
        // Step row starts until the first one beyond the cursor.
        if (nb_q > cur_q) begin
          cur_d   = nb_q;
          state_d = S_FIN;
        end else begin
          nb_d = nb_q + COLS_C;
        end
      end

      S_RDWAIT: begin
        if (out_free) begin
          fin      = 1'b1;
          fin_char = mem_rdata.ch;
          fin_attr = mem_rdata.attr;
        end
      end

      S_FIN: begin
        fin = out_free;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      ov_d     = 1'b1;
      o_cur_d  = POS_W'(fin_cur);
      o_char_d = fin_char;
      o_attr_d = fin_attr;
      o_scr_d  = scr_q;
      state_d  = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_q       <= '0;
      k_q         <= '0;
      nb_q        <= '0;
      pend_q      <= 1'b0;
      pend_copy_q <= 1'b0;
      pend_addr_q <= '0;
      scr_q       <= 1'b0;
      mode_q      <= MODE_PUT;
      char_q      <= '0;
      pos_q       <= '0;
      attr_q      <= RESET_ATTR;
      ov_q        <= 1'b0;
      o_cur_q     <= '0;
      o_char_q    <= '0;
      o_attr_q    <= '0;
      o_scr_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      k_q         <= k_d;
      nb_q        <= nb_d;
      pend_q      <= pend_d;
      pend_copy_q <= pend_copy_d;
      pend_addr_q <= pend_addr_d;
      scr_q       <= scr_d;
      mode_q      <= mode_d;
      char_q      <= char_d;
      pos_q       <= pos_d;
      attr_q      <= attr_d;
      ov_q        <= ov_d;
      o_cur_q     <= o_cur_d;
      o_char_q    <= o_char_d;
      o_attr_q    <= o_attr_d;
      o_scr_q     <= o_scr_d;
    end
  end

endmodule

@@ rtl/tcw_checker.sv @@
// Port-level checks of the text console writer and their binding to the top level.
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  localparam int  CELLS    = ROWS * COLUMNS;
  localparam bit  FITS     = (CELLS < (1 << POS_W));
  localparam logic [POS_W-1:0] CELLS_P = POS_W'(CELLS);

  // Only one item is in flight: an input beat is never followed by another at once.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // A scroll only happens on a put, which never reports cell contents.
  a_scroll_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[26:11] == 16'h0000)
    else $error("scrolled result carries cell data");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !FITS || (m_axis_tdata[10:0] <= CELLS_P))
    else $error("cursor beyond the end of the screen");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);
